/* rtl/core/lpsd_pkg.sv */
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants for the length-prefixed string decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

    localparam int COUNT_BITS_DEF = 32;

    // varint groups: 7 payload bits each, groups at index 5 and up add nothing
    localparam int GRP_BITS   = 3;
    localparam int GRP_SAT    = 5;
    localparam int TERM_BITS  = 35;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_LEAD = 3'b010,
        PH_CONT = 3'b100
    } phase_t;

endpackage

`default_nettype wire

/* rtl/core/length_prefixed_utf8_string_decoder_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_utf8_string_decoder_top
// Decodes a byte stream of varint-prefixed modified UTF-8 strings into
// 16-bit characters, flagging the last character and empty strings.
// ----------------------------------------------------------------------------
//  channel  dir  ports                                   transaction
//  s_       in   s_valid s_ready s_byte_in               one raw byte
//  m_       out  m_valid m_ready m_code_unit m_last      zero or one char
//                m_empty_res
//
//  One byte per cycle while s_ready is high; the decode state and, when a
//  character finishes, the output register both load on the accepting
//  edge, so the character is offered on m_ from the next cycle on.
//  s_ready is high while the output register is empty or being drained.
//  aresetn is synchronous, active low; it clears the decode state and
//  m_valid. A stalled m_ready holds the result and stalls s_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_utf8_string_decoder_top
    import lpsd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_unit,
    output logic             m_last,
    output logic             m_empty_res
);

    phase_t                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [GRP_BITS-1:0]     grp_reg, grp_next;
    logic [COUNT_BITS-1:0]   left_reg, left_next;
    logic [15:0]             part_reg, part_next;
    logic [1:0]              pend_reg, pend_next;

    logic                    m_valid_reg, m_valid_next;
    logic [15:0]             code_reg, code_next;
    logic                    last_reg, last_next;
    logic                    empty_reg, empty_next;

    logic                    accept;
    logic                    emit;
    logic [COUNT_BITS-1:0]   term;
    logic [COUNT_BITS-1:0]   count_sum;
    logic [COUNT_BITS-1:0]   left_dec;
    logic [15:0]             cont_char;

    assign s_ready     = ~m_valid_reg | m_ready;
    assign accept      = s_valid & s_ready;
    assign m_valid     = m_valid_reg;
    assign m_code_unit = code_reg;
    assign m_last      = last_reg;
    assign m_empty_res = empty_reg;

    always_comb begin
        case (grp_reg)
            3'd0:    term = COUNT_BITS'(TERM_BITS'(s_byte_in[6:0]));
            3'd1:    term = COUNT_BITS'(TERM_BITS'(s_byte_in[6:0]) << 7);
            3'd2:    term = COUNT_BITS'(TERM_BITS'(s_byte_in[6:0]) << 14);
            3'd3:    term = COUNT_BITS'(TERM_BITS'(s_byte_in[6:0]) << 21);
            3'd4:    term = COUNT_BITS'(TERM_BITS'(s_byte_in[6:0]) << 28);
            default: term = '0;
        endcase
    end

    assign count_sum = count_reg | term;
    assign left_dec  = left_reg - COUNT_BITS'(1);
    assign cont_char = (pend_reg == 2'd2) ? (part_reg | {4'd0, s_byte_in[5:0], 6'd0})
                                          : (part_reg | {10'd0, s_byte_in[5:0]});

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        grp_next   = grp_reg;
        left_next  = left_reg;
        part_next  = part_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        code_next  = code_reg;
        last_next  = last_reg;
        empty_next = empty_reg;

        if (accept) begin
            case (phase_reg)
                PH_LEAD: begin
                    if (!s_byte_in[7]) begin
                        emit       = 1'b1;
                        code_next  = {9'd0, s_byte_in[6:0]};
                        last_next  = (left_dec == '0);
                        empty_next = 1'b0;
                        left_next  = left_dec;
                        phase_next = (left_dec == '0) ? PH_LEN : PH_LEAD;
                        part_next  = '0;
                        pend_next  = '0;
                    end else if (s_byte_in[7:5] != 3'b111) begin
                        part_next  = {5'd0, s_byte_in[4:0], 6'd0};
                        pend_next  = 2'd1;
                        phase_next = PH_CONT;
                    end else begin
                        part_next  = {s_byte_in[3:0], 12'd0};
                        pend_next  = 2'd2;
                        phase_next = PH_CONT;
                    end
                end
                PH_CONT: begin
                    if (pend_reg == 2'd2) begin
                        part_next = cont_char;
                        pend_next = 2'd1;
                    end else begin
                        emit       = 1'b1;
                        code_next  = cont_char;
                        last_next  = (left_dec == '0);
                        empty_next = 1'b0;
                        left_next  = left_dec;
                        phase_next = (left_dec == '0) ? PH_LEN : PH_LEAD;
                        part_next  = '0;
                        pend_next  = '0;
                    end
                end
                default: begin
                    if (s_byte_in[7]) begin
                        count_next = count_sum;
                        grp_next   = (grp_reg >= GRP_BITS'(GRP_SAT)) ? GRP_BITS'(GRP_SAT)
                                                                    : grp_reg + GRP_BITS'(1);
                        phase_next = PH_LEN;
                    end else begin
                        left_next  = count_sum;
                        count_next = '0;
                        grp_next   = '0;
                        part_next  = '0;
                        pend_next  = '0;
                        if (count_sum == '0) begin
                            emit       = 1'b1;
                            code_next  = '0;
                            last_next  = 1'b1;
                            empty_next = 1'b1;
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = PH_LEAD;
                        end
                    end
                end
            endcase
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN;
            count_reg   <= '0;
            grp_reg     <= '0;
            left_reg    <= '0;
            part_reg    <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            grp_reg     <= grp_next;
            left_reg    <= left_next;
            part_reg    <= part_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

endmodule

`default_nettype wire

/* sim/length_prefixed_utf8_string_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_utf8_string_decoder_top_tb
// Drives a byte stream of varint-prefixed modified UTF-8 strings into the
// decoder and checks every character that comes out against a behavioral
// decoder kept in the bench or, for some directed rows, a typed result. The
// run starts with a short directed table (empty strings, extreme characters,
// padded and over-long counts), then random strings, truncated strings and
// stray bytes under several sender/receiver throttling mixes, a long
// receiver hold-off, and finally a string whose count has bit 31 set.
// ----------------------------------------------------------------------------
module length_prefixed_utf8_string_decoder_top_tb
    import lpsd_pkg::*;
();

    typedef struct packed {
        logic [15:0] code;
        logic        last;
        logic        empty;
    } char_res_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        char_res_t  res;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam int PHASES   = 5;
    localparam int PHASE_BYTES = 160;

    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b1, '{16'h0000, 1'b1, 1'b1}},
        '{8'h01, 1'b0, '0},
        '{8'h7F, 1'b1, '{16'h007F, 1'b1, 1'b0}},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{8'hC0, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hDF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hEF, 1'b0, '0},
        '{8'hBF, 1'b0, '0},
        '{8'h3F, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b1, '{16'h0000, 1'b1, 1'b1}},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h10, 1'b1, '{16'h0000, 1'b1, 1'b1}}
    };

    localparam int IDLE_PCT  [0:PHASES-1] = '{0, 82, 0, 25, 0};
    localparam int STALL_PCT [0:PHASES-1] = '{0, 0, 82, 25, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_last;
    logic        m_empty_res;

    // bench-side decoder state
    phase_t      dec_phase = PH_LEN;
    logic [31:0] len_accum = '0;
    logic [5:0]  len_shift = '0;
    logic [31:0] chars_left = '0;
    logic [15:0] char_acc = '0;
    logic [1:0]  cont_left = '0;

    char_res_t   pending_chars[$];
    char_res_t   head;

    int send_idle = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int mismatches = 0;
    int bytes_sent = 0;
    int chars_checked = 0;
    int empties_checked = 0;
    int broken_strings = 0;

    length_prefixed_utf8_string_decoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_last      (m_last),
        .m_empty_res (m_empty_res)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic char_res_t finish_char(input logic [15:0] ch);
        char_res_t r;
        chars_left = chars_left - 32'd1;
        r.code = ch;
        r.last = (chars_left == 0);
        r.empty = 1'b0;
        dec_phase = (chars_left == 0) ? PH_LEN : PH_LEAD;
        char_acc = '0;
        cont_left = '0;
        return r;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output char_res_t r);
        logic [63:0] grp;
        bit has;
        has = 1'b0;
        r = '0;
        case (dec_phase)
            PH_LEAD: begin
                if (!b[7]) begin
                    r = finish_char({9'b0, b[6:0]});
                    has = 1'b1;
                end else begin
                    if (b[7:5] != 3'b111) begin
                        char_acc = {5'b0, b[4:0], 6'b0};
                        cont_left = 2'd1;
                    end else begin
                        char_acc = {b[3:0], 12'b0};
                        cont_left = 2'd2;
                    end
                    dec_phase = PH_CONT;
                end
            end
            PH_CONT: begin
                if (cont_left >= 2)
                    char_acc = char_acc | {4'b0, b[5:0], 6'b0};
                else
                    char_acc = char_acc | {10'b0, b[5:0]};
                if (cont_left != 0)
                    cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    r = finish_char(char_acc);
                    has = 1'b1;
                end
            end
            default: begin
                if (len_shift < 32) begin
                    grp = {57'b0, b[6:0]} << len_shift;
                    len_accum = len_accum | grp[31:0];
                end
                if (b[7]) begin
                    len_shift = (len_shift > 56) ? 6'd63 : len_shift + 6'd7;
                    dec_phase = PH_LEN;
                end else begin
                    chars_left = len_accum;
                    len_accum = '0;
                    len_shift = '0;
                    char_acc = '0;
                    cont_left = '0;
                    if (chars_left == 0) begin
                        r = '{16'h0000, 1'b1, 1'b1};
                        has = 1'b1;
                        dec_phase = PH_LEN;
                    end else begin
                        dec_phase = PH_LEAD;
                    end
                end
            end
        endcase
        return has;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input char_res_t typed_res = '0);
        char_res_t r;
        bit has;
        s_valid <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        has = decode_byte(b, r);
        bytes_sent++;
        if (typed)
            pending_chars.push_back(typed_res);
        else if (has)
            pending_chars.push_back(r);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic send_char();
        int t;
        t = $urandom_range(99);
        if (t < 50) begin
            send_byte(8'($urandom_range(127)));
        end else if (t < 80) begin
            send_byte(8'($urandom_range(8'hDF, 8'h80)));
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(8'hFF, 8'hE0)));
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // finish whatever string is open so the next byte is a fresh count
    task automatic resync();
        while (!(dec_phase == PH_LEN && len_shift == 0)) begin
            case (dec_phase)
                PH_LEAD: send_byte(8'($urandom_range(127)));
                PH_CONT: send_byte(8'($urandom_range(255)));
                default: send_byte(8'h00);
            endcase
        end
    endtask

    task automatic send_string(input bit broken);
        int t;
        int n;
        int minimal;
        int groups;
        int grp_val;
        int sent_chars;
        logic [7:0] g;
        t = $urandom_range(99);
        if (t < 10)
            n = 0;
        else if (t < 80)
            n = $urandom_range(6, 1);
        else if (t < 95)
            n = $urandom_range(40, 7);
        else
            n = $urandom_range(160, 100);
        minimal = (n < 128) ? 1 : 2;
        groups = ($urandom_range(7) == 0) ? $urandom_range(12, minimal) : minimal;
        for (int k = 0; k < groups; k++) begin
            if (k < 5) begin
                grp_val = (n >> (7 * k)) & 127;
                g = grp_val[7:0];
                if (k == 4)
                    g[6:4] = 3'($urandom_range(7));
            end else begin
                g = 8'($urandom_range(127));
            end
            g[7] = (k < groups - 1);
            send_byte(g);
        end
        sent_chars = (broken && n > 0) ? $urandom_range(n - 1) : n;
        repeat (sent_chars) send_char();
        if (broken && n > 0) begin
            broken_strings++;
            if ($urandom_range(1))
                send_byte(8'($urandom_range(8'hFF, 8'h80)));
        end
        resync();
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", 32'(m_code_unit), 32'd0);
            end else begin
                head = pending_chars.pop_front();
                chars_checked++;
                if (head.empty)
                    empties_checked++;
                if (m_code_unit !== head.code)
                    report_mismatch("code_unit", 32'(m_code_unit), 32'(head.code));
                if (m_last !== head.last)
                    report_mismatch("last", 32'(m_last), 32'(head.last));
                if (m_empty_res !== head.empty)
                    report_mismatch("empty_res", 32'(m_empty_res), 32'(head.empty));
            end
        end
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase_start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].b, DIR_TABLE[i].typed, DIR_TABLE[i].res);
        drain_outputs();

        for (int p = 0; p < PHASES; p++) begin
            send_idle = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == PHASES - 1)
                hold_req <= 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(49) == 0) begin
                    send_byte(8'($urandom_range(255)));
                    resync();
                end else begin
                    send_string($urandom_range(9) == 0);
                end
            end
            drain_outputs();
        end

        // count 0x80000001: bit 31 set, bits above 31 dropped; never completes
        send_byte(8'h81);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h78);
        repeat (6) send_char();
        drain_outputs();
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes: directed table, %0d throttling phases, %0d truncated strings",
                 bytes_sent, PHASES, broken_strings);
        $display("Checked %0d characters (%0d empty markers), %0d mismatches",
                 chars_checked, empties_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
